>>> rtl/core/rfvb_pkg.sv
// ----------------------------------------------------------------------------
// rfvb_pkg
// Types, widths and register codes shared by the radial falloff blend core.
// ----------------------------------------------------------------------------
package rfvb_pkg;

  localparam int COORD_BITS = 10;
  localparam int GRID_BITS  = 11;
  localparam int SPIN_BITS  = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;

  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int D2_BITS    = SQ_BITS + 1;
  localparam int SQ_SHIFT   = 30;
  localparam int ROOT_BITS  = 26;
  localparam int V_PAD      = 2 * ROOT_BITS - D2_BITS - SQ_SHIFT;
  localparam int REM_BITS   = ROOT_BITS + 2;

  localparam int STR_BITS   = 17;
  localparam logic [STR_BITS-1:0] STR_ONE = STR_BITS'(32768);
  localparam int PROD_BITS  = STR_BITS + 1 + SPIN_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int FRAC_BITS  = SPIN_BITS - 1;
  localparam int SH_BITS    = SUM_BITS - FRAC_BITS;

  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY      = FRONT_STAGES + 2 * ROOT_BITS + BACK_STAGES;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_POL_X       = 3'd3,
    REG_POL_Y       = 3'd4,
    REG_POL_Z       = 3'd5,
    REG_GRID_WIDTH  = 3'd6,
    REG_GRID_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]       site_x;
    logic [COORD_BITS-1:0]       site_y;
    logic signed [SPIN_BITS-1:0] spin_x;
    logic signed [SPIN_BITS-1:0] spin_y;
    logic signed [SPIN_BITS-1:0] spin_z;
  } in_t;

  typedef struct packed {
    logic signed [SPIN_BITS-1:0] new_x;
    logic signed [SPIN_BITS-1:0] new_y;
    logic signed [SPIN_BITS-1:0] new_z;
    logic                        inside_disk;
  } out_t;

  typedef struct packed {
    logic                        in_disk;
    logic signed [SPIN_BITS-1:0] spin_x;
    logic signed [SPIN_BITS-1:0] spin_y;
    logic signed [SPIN_BITS-1:0] spin_z;
  } side_t;

endpackage

>>> rtl/core/rfvb_isqrt.sv
// ----------------------------------------------------------------------------
// rfvb_isqrt
// Pipelined integer square root of d2 * 2^30, one root bit per stage.
// ----------------------------------------------------------------------------
module rfvb_isqrt import rfvb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [D2_BITS-1:0]   d2,
  input  side_t                side_in,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] root,
  output side_t                side_out
);

  logic                 valid_q [ROOT_BITS];
  logic [D2_BITS-1:0]   d2_q    [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_q   [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q  [ROOT_BITS];
  side_t                side_q  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic                   c_valid;
    logic [D2_BITS-1:0]     c_d2;
    logic [REM_BITS-1:0]    c_rem;
    logic [ROOT_BITS-1:0]   c_root;
    side_t                  c_side;
    logic [2*ROOT_BITS-1:0] v;
    logic [REM_BITS+1:0]    sh;
    logic [REM_BITS+1:0]    trial;
    logic [REM_BITS+1:0]    diff;
    logic                   ge;

    if (k == 0) begin : g_first
      always_comb begin
        c_valid = in_valid;
        c_d2    = d2;
        c_rem   = '0;
        c_root  = '0;
        c_side  = side_in;
      end
    end else begin : g_next
      always_comb begin
        c_valid = valid_q[k-1];
        c_d2    = d2_q[k-1];
        c_rem   = rem_q[k-1];
        c_root  = root_q[k-1];
        c_side  = side_q[k-1];
      end
    end

    always_comb begin
      v     = {{V_PAD{1'b0}}, c_d2, {SQ_SHIFT{1'b0}}};
      sh    = {c_rem, v[2*ROOT_BITS-1-2*k -: 2]};
      trial = {{(REM_BITS-ROOT_BITS){1'b0}}, c_root, 2'b01};
      ge    = (sh >= trial);
      diff  = sh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= c_valid;
      end
      d2_q[k]   <= c_d2;
      rem_q[k]  <= ge ? diff[REM_BITS-1:0] : sh[REM_BITS-1:0];
      root_q[k] <= {c_root[ROOT_BITS-2:0], ge};
      side_q[k] <= c_side;
    end
  end

  assign out_valid = valid_q[ROOT_BITS-1];
  assign root      = root_q[ROOT_BITS-1];
  assign side_out  = side_q[ROOT_BITS-1];

endmodule

>>> rtl/core/rfvb_div.sv
// ----------------------------------------------------------------------------
// rfvb_div
// Pipelined restoring divide of the root by the radius, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module rfvb_div import rfvb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [ROOT_BITS-1:0]  num,
  input  logic [COORD_BITS-1:0] radius,
  input  side_t                 side_in,
  output logic                  out_valid,
  output logic [ROOT_BITS-1:0]  quo,
  output side_t                 side_out
);

  logic                  valid_q [ROOT_BITS];
  logic [ROOT_BITS-1:0]  num_q   [ROOT_BITS];
  logic [COORD_BITS-1:0] rem_q   [ROOT_BITS];
  logic [ROOT_BITS-1:0]  quo_q   [ROOT_BITS];
  side_t                 side_q  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic                  c_valid;
    logic [ROOT_BITS-1:0]  c_num;
    logic [COORD_BITS-1:0] c_rem;
    logic [ROOT_BITS-1:0]  c_quo;
    side_t                 c_side;
    logic [COORD_BITS:0]   sh;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    if (k == 0) begin : g_first
      always_comb begin
        c_valid = in_valid;
        c_num   = num;
        c_rem   = '0;
        c_quo   = '0;
        c_side  = side_in;
      end
    end else begin : g_next
      always_comb begin
        c_valid = valid_q[k-1];
        c_num   = num_q[k-1];
        c_rem   = rem_q[k-1];
        c_quo   = quo_q[k-1];
        c_side  = side_q[k-1];
      end
    end

    always_comb begin
      sh   = {c_rem, c_num[ROOT_BITS-1-k]};
      ge   = (sh >= {1'b0, radius});
      diff = sh - {1'b0, radius};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= c_valid;
      end
      num_q[k]  <= c_num;
      rem_q[k]  <= ge ? diff[COORD_BITS-1:0] : sh[COORD_BITS-1:0];
      quo_q[k]  <= {c_quo[ROOT_BITS-2:0], ge};
      side_q[k] <= c_side;
    end
  end

  assign out_valid = valid_q[ROOT_BITS-1];
  assign quo       = quo_q[ROOT_BITS-1];
  assign side_out  = side_q[ROOT_BITS-1];

endmodule

>>> rtl/core/radial_falloff_vector_blend_core.sv
// ----------------------------------------------------------------------------
// radial_falloff_vector_blend_core
// Blends lattice spins toward a target vector with a linear radial falloff.
//
// Input: one site word (coordinates and spin) is taken at each rising edge
// with start high and busy low. busy stays low, so a word may enter every
// cycle: throughput is one site per clock.
// Output: each site gives one result word, shown on result for exactly one
// cycle with result_valid high. Results leave in input order. The receiver
// cannot stall, so nothing is held back.
// Pipeline: 3 front stages (distance, squares, sum and compare), 26 square
// root stages, 26 divide stages and 3 blend stages (strength, multiply,
// round and saturate).
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// write only while no site is in flight.
// Reset: rst (synchronous) empties the pipeline and restores the register
// defaults: center 0,0, radius 1, target 0,0,32767, grid 1024 x 1024.
// ----------------------------------------------------------------------------
module radial_falloff_vector_blend_core import rfvb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_t                 item,
  output logic                result_valid,
  output out_t                result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic [COORD_BITS-1:0]       center_x;
  logic [COORD_BITS-1:0]       center_y;
  logic [COORD_BITS-1:0]       radius;
  logic signed [SPIN_BITS-1:0] pol     [3];
  logic [GRID_BITS-1:0]        grid_width;
  logic [GRID_BITS-1:0]        grid_height;
  logic [SQ_BITS-1:0]          r2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      radius      <= COORD_BITS'(1);
      pol[0]      <= '0;
      pol[1]      <= '0;
      pol[2]      <= SPIN_BITS'(32767);
      grid_width  <= GRID_BITS'(1024);
      grid_height <= GRID_BITS'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_CENTER_X:    center_x    <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS:      radius      <= cfg_data[COORD_BITS-1:0];
        REG_POL_X:       pol[0]      <= cfg_data[SPIN_BITS-1:0];
        REG_POL_Y:       pol[1]      <= cfg_data[SPIN_BITS-1:0];
        REG_POL_Z:       pol[2]      <= cfg_data[SPIN_BITS-1:0];
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= SQ_BITS'(radius) * SQ_BITS'(radius);
  end

  // front: distance, squares, sum and disk test
  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  in_grid1, in_grid2;
  side_t                 side1, side2, side3;
  logic [SQ_BITS-1:0]    sq_x, sq_y;
  logic [D2_BITS-1:0]    d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
    dx <= (item.site_x > center_x) ? item.site_x - center_x : center_x - item.site_x;
    dy <= (item.site_y > center_y) ? item.site_y - center_y : center_y - item.site_y;
    in_grid1 <= ({1'b0, item.site_x} < grid_width) && ({1'b0, item.site_y} < grid_height);
    side1 <= '{in_disk: 1'b0, spin_x: item.spin_x, spin_y: item.spin_y, spin_z: item.spin_z};

    sq_x     <= SQ_BITS'(dx) * SQ_BITS'(dx);
    sq_y     <= SQ_BITS'(dy) * SQ_BITS'(dy);
    in_grid2 <= in_grid1;
    side2    <= side1;

    d2    <= D2_BITS'(sq_x) + D2_BITS'(sq_y);
    side3 <= '{in_disk: in_grid2 && ((D2_BITS'(sq_x) + D2_BITS'(sq_y)) <= D2_BITS'(r2)),
               spin_x: side2.spin_x, spin_y: side2.spin_y, spin_z: side2.spin_z};
  end

  logic                 sq_valid;
  logic [ROOT_BITS-1:0] root;
  side_t                sq_side;
  logic                 dv_valid;
  logic [ROOT_BITS-1:0] quo;
  side_t                dv_side;

  rfvb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .d2       (d2),
    .side_in  (side3),
    .out_valid(sq_valid),
    .root     (root),
    .side_out (sq_side)
  );

  rfvb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .num      (root),
    .radius   (radius),
    .side_in  (sq_side),
    .out_valid(dv_valid),
    .quo      (quo),
    .side_out (dv_side)
  );

  // back: strength, products, round and saturate
  logic                        v4, v5;
  logic [STR_BITS-1:0]         str, wgt;
  side_t                       side4, side5;
  logic signed [PROD_BITS-1:0] p_pol  [3];
  logic signed [PROD_BITS-1:0] p_spin [3];
  logic signed [SPIN_BITS-1:0] spin4  [3];
  logic [STR_BITS-1:0]         t_clamp;

  always_comb begin
    t_clamp = (quo > ROOT_BITS'(STR_ONE)) ? STR_ONE : quo[STR_BITS-1:0];
    spin4[0] = side4.spin_x;
    spin4[1] = side4.spin_y;
    spin4[2] = side4.spin_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= dv_valid;
      v5 <= v4;
    end
    if (radius == '0) begin
      str <= STR_ONE;
      wgt <= '0;
    end else begin
      str <= STR_ONE - t_clamp;
      wgt <= t_clamp;
    end
    side4 <= dv_side;

    for (int i = 0; i < 3; i++) begin
      p_pol[i]  <= $signed({1'b0, str}) * pol[i];
      p_spin[i] <= $signed({1'b0, wgt}) * spin4[i];
    end
    side5 <= side4;
  end

  logic signed [SUM_BITS-1:0]  sum  [3];
  logic signed [SH_BITS-1:0]   shr  [3];
  logic signed [SPIN_BITS-1:0] sat  [3];
  logic signed [SPIN_BITS-1:0] max_v;
  logic signed [SPIN_BITS-1:0] min_v;

  always_comb begin
    max_v = {1'b0, {(SPIN_BITS-1){1'b1}}};
    min_v = {1'b1, {(SPIN_BITS-1){1'b0}}};
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_BITS'(p_pol[i]) + SUM_BITS'(p_spin[i])
             + $signed(SUM_BITS'(1 << (FRAC_BITS - 1)));
      shr[i] = sum[i][SUM_BITS-1:FRAC_BITS];
      priority if (shr[i] > SH_BITS'(max_v)) begin
        sat[i] = max_v;
      end else if (shr[i] < SH_BITS'(min_v)) begin
        sat[i] = min_v;
      end else begin
        sat[i] = shr[i][SPIN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v5;
    end
    if (side5.in_disk) begin
      result <= '{new_x: sat[0], new_y: sat[1], new_z: sat[2], inside_disk: 1'b1};
    end else begin
      result <= '{new_x: side5.spin_x, new_y: side5.spin_y, new_z: side5.spin_z,
                  inside_disk: 1'b0};
    end
  end

endmodule

>>> rtl/core/rfvb_checker.sv
// ----------------------------------------------------------------------------
// rfvb_checker
// Port-level timing and pass-through checks for the radial falloff blend core.
// ----------------------------------------------------------------------------
module rfvb_checker import rfvb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  item,
  input logic result_valid,
  input out_t result
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY result_valid)
    else $error("site word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching site word");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.inside_disk) |->
      (result.new_x == $past(item.spin_x, LATENCY)) &&
      (result.new_y == $past(item.spin_y, LATENCY)) &&
      (result.new_z == $past(item.spin_z, LATENCY)))
    else $error("unblended site altered");

endmodule

bind radial_falloff_vector_blend_core rfvb_checker u_rfvb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .item        (item),
  .result_valid(result_valid),
  .result      (result)
);

>>> test/radial_falloff_vector_blend_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_falloff_vector_blend_core_tb
// Drives site words through the blend core under several register settings,
// with random gaps between starts, and checks every result word in order
// against a bit-exact predictor of the radial falloff blend.
// ----------------------------------------------------------------------------
module radial_falloff_vector_blend_core_tb;
  import rfvb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 550;
  localparam int DRAIN       = LATENCY + 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_t                 item = '0;
  logic                result_valid;
  out_t                result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  radial_falloff_vector_blend_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register copy for the predictor
  logic [9:0]         m_cx, m_cy, m_rad;
  logic signed [15:0] m_px, m_py, m_pz;
  logic [10:0]        m_gw, m_gh;

  out_t   blend_queue[$];
  int     errors = 0;
  longint cycles = 0;

  typedef struct {
    in_t  site;
    logic fixed;
    out_t want;
  } row_t;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic signed [15:0] mix(input longint s, input longint pol,
                                             input longint spin);
    longint sum, r;
    sum = s * pol + (32768 - s) * spin + 16384;
    r = sum >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic out_t blend_site(input in_t d);
    out_t   o;
    longint gw, gh, dx, dy, d2, s, t;
    gw = (m_gw > 1024) ? 1024 : m_gw;
    gh = (m_gh > 1024) ? 1024 : m_gh;
    dx = longint'(d.site_x) - longint'(m_cx);
    dy = longint'(d.site_y) - longint'(m_cy);
    d2 = dx * dx + dy * dy;
    if (!(d.site_x < gw && d.site_y < gh && d2 <= longint'(m_rad) * m_rad)) begin
      o.new_x = d.spin_x;
      o.new_y = d.spin_y;
      o.new_z = d.spin_z;
      o.inside_disk = 1'b0;
      return o;
    end
    if (m_rad == 0) begin
      s = 32768;
    end else begin
      t = isqrt(64'(d2) << 30) / m_rad;
      if (t > 32768) t = 32768;
      s = 32768 - t;
    end
    o.new_x = mix(s, m_px, d.spin_x);
    o.new_y = mix(s, m_py, d.spin_y);
    o.new_z = mix(s, m_pz, d.spin_z);
    o.inside_disk = 1'b1;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t w;
    if (!rst && result_valid) begin
      if (blend_queue.size() == 0) begin
        report("result word with none expected");
      end else begin
        w = blend_queue.pop_front();
        if (result.new_x !== w.new_x)
          report($sformatf("new_x %0d want %0d", result.new_x, w.new_x));
        if (result.new_y !== w.new_y)
          report($sformatf("new_y %0d want %0d", result.new_y, w.new_y));
        if (result.new_z !== w.new_z)
          report($sformatf("new_z %0d want %0d", result.new_z, w.new_z));
        if (result.inside_disk !== w.inside_disk)
          report($sformatf("inside_disk %0b want %0b", result.inside_disk,
                           w.inside_disk));
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_X:    m_cx = val[9:0];
      REG_CENTER_Y:    m_cy = val[9:0];
      REG_RADIUS:      m_rad = val[9:0];
      REG_POL_X:       m_px = val;
      REG_POL_Y:       m_py = val;
      REG_POL_Z:       m_pz = val;
      REG_GRID_WIDTH:  m_gw = val[10:0];
      REG_GRID_HEIGHT: m_gh = val[10:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (blend_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_site(input in_t d, input out_t want, input logic fixed);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= d;
    do @(posedge clk); while (busy);
    blend_queue.push_back(fixed ? want : blend_site(d));
  endtask

  function automatic in_t rand_site(input int near);
    in_t d;
    int  off;
    if (near != 0) begin
      off = $urandom_range(0, 2 * m_rad + 2);
      d.site_x = 10'(int'(m_cx) + off - int'(m_rad) - 1);
      off = $urandom_range(0, 2 * m_rad + 2);
      d.site_y = 10'(int'(m_cy) + off - int'(m_rad) - 1);
    end else begin
      d.site_x = 10'($urandom);
      d.site_y = 10'($urandom);
    end
    d.spin_x = 16'($urandom);
    d.spin_y = 16'($urandom);
    d.spin_z = 16'($urandom);
    if ($urandom_range(0, 7) == 0) d.spin_x = 16'sh8000;
    if ($urandom_range(0, 7) == 0) d.spin_z = 16'sh7fff;
    return d;
  endfunction

  task automatic set_all(input int cx, input int cy, input int rad, input int px,
                         input int py, input int pz, input int gw, input int gh);
    write_reg(REG_CENTER_X, 16'(cx));
    write_reg(REG_CENTER_Y, 16'(cy));
    write_reg(REG_RADIUS, 16'(rad));
    write_reg(REG_POL_X, 16'(px));
    write_reg(REG_POL_Y, 16'(py));
    write_reg(REG_POL_Z, 16'(pz));
    write_reg(REG_GRID_WIDTH, 16'(gw));
    write_reg(REG_GRID_HEIGHT, 16'(gh));
  endtask

  initial begin
    row_t rows[$];
    out_t none;
    int   phase;
    int   k;
    none = '0;
    m_cx = 0; m_cy = 0; m_rad = 1;
    m_px = 0; m_py = 0; m_pz = 16'sd32767;
    m_gw = 1024; m_gh = 1024;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: center site takes the target vector exactly
    rows.push_back('{'{10'd0, 10'd0, 16'sd100, -16'sd200, 16'sd300}, 1'b1,
                    '{16'sd0, 16'sd0, 16'sd32767, 1'b1}});
    rows.push_back('{'{10'd1, 10'd0, 16'sd100, -16'sd200, 16'sd300}, 1'b1,
                    '{16'sd100, -16'sd200, 16'sd300, 1'b1}});
    rows.push_back('{'{10'd1, 10'd1, 16'sh7fff, 16'sh8000, 16'sd5}, 1'b1,
                    '{16'sh7fff, 16'sh8000, 16'sd5, 1'b0}});
    rows.push_back('{'{10'd1023, 10'd1023, 16'sh8000, 16'sh7fff, -16'sd1}, 1'b1,
                    '{16'sh8000, 16'sh7fff, -16'sd1, 1'b0}});
    foreach (rows[i]) send_site(rows[i].site, rows[i].want, rows[i].fixed);
    drain();

    // radius zero and edge grid, then extreme targets
    set_all(512, 512, 0, 16'h8000, 16'h7fff, 16'h0000, 2047, 1024);
    rows.delete();
    rows.push_back('{'{10'd512, 10'd512, 16'sd7, 16'sd8, 16'sd9}, 1'b1,
                    '{16'sh8000, 16'sh7fff, 16'sd0, 1'b1}});
    rows.push_back('{'{10'd513, 10'd512, 16'sd7, 16'sd8, 16'sd9}, 1'b1,
                    '{16'sd7, 16'sd8, 16'sd9, 1'b0}});
    rows.push_back('{'{10'd1023, 10'd0, 16'sd1, 16'sd2, 16'sd3}, 1'b0, none});
    foreach (rows[i]) send_site(rows[i].site, rows[i].want, rows[i].fixed);
    drain();
    set_all(1023, 1023, 1023, 16'h8000, 16'h8000, 16'h7fff, 1024, 1024);
    for (k = 0; k < 8; k++) send_site(rand_site(k % 2), none, 1'b0);
    send_site('{10'd0, 10'd0, 16'sd1, 16'sd1, 16'sd1}, none, 1'b0);
    send_site('{10'd1023, 10'd0, 16'sh7fff, 16'sh8000, 16'sd0}, none, 1'b0);
    drain();
    // grid of zero size: every site passes
    set_all(0, 0, 5, 16'h1234, 16'h4321, 16'h7fff, 0, 0);
    send_site('{10'd0, 10'd0, 16'sd11, 16'sd12, 16'sd13}, '{16'sd11, 16'sd12,
              16'sd13, 1'b0}, 1'b1);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      set_all($urandom_range(0, 1023), $urandom_range(0, 1023),
              phase == 0 ? 1 : $urandom_range(0, phase < 3 ? 40 : 1023),
              $urandom, $urandom, $urandom,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : 1024,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : 1024);
      for (k = 0; k < N_RANDOM / 6; k++)
        send_site(rand_site($urandom_range(0, 4) != 0), none, 1'b0);
      drain();
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && blend_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
